// ----- rtl/core/minimum_spanning_tree_weight_macros.svh -----
// Assertion helpers for the spanning tree block.
`ifndef MINIMUM_SPANNING_TREE_WEIGHT_MACROS_SVH
`define MINIMUM_SPANNING_TREE_WEIGHT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MSTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%s failed", "label");

// Next-cycle implication checked outside reset.
`define MSTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%s failed", "label");

`endif

// ----- rtl/core/mstw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mstw_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int WEIGHT_BITS = 16;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int END_W = 11;
  localparam int TOT_W = 26;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_VCOUNT = '0;

  typedef struct packed {
    logic [END_W-1:0] a;
    logic [END_W-1:0] b;
    logic [WEIGHT_BITS-1:0] w;
  } edge_t;

  typedef struct packed {
    logic [END_W-1:0] end_a;
    logic [END_W-1:0] end_b;
    logic [15:0] weight;
    logic last_edge;
  } in_word_t;

  typedef struct packed {
    logic [TOT_W-1:0] total_weight;
    logic connected;
    logic edges_dropped;
  } out_word_t;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_SPASS, S_SRD, S_SWAIT, S_SCMP, S_SCOPY, S_SCPW,
    S_KRD, S_KWAIT, S_KCHK, S_FA, S_FAW, S_FB, S_FBW, S_CA, S_CAW, S_CB, S_CBW,
    S_JOIN, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/mstw_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mstw_in_if;
  logic valid;
  logic ready;
  mstw_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mstw_out_if;
  logic valid;
  logic ready;
  mstw_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/minimum_spanning_tree_weight.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Word
// in_      sink       end_a, end_b, weight, last_edge
// out_     source     total_weight, connected, edges_dropped
// cfg_     APB slave  vertex_count at byte address 0
//
// An edge word that is not last is taken and written to the edge store while it has room.
// A last word starts the solve and holds in_ready low until it ends: parent init, a
// bottom-up merge sort between two banks of the edge store over ceil(log2(E)) passes,
// then Kruskal with a root search and path compression for the ends of each edge.
// Reset is synchronous; the result waits in an output register until taken.
module minimum_spanning_tree_weight (
  input  wire logic clk,
  input  wire logic rst_n,
  mstw_in_if.sink in_ch,
  mstw_out_if.source out_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [mstw_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int EW = mstw_pkg::EW;
  localparam int VW = mstw_pkg::VW;

  logic [10:0] vcount_r;
  logic [EW:0] fill_r, fill_nxt;
  logic ovf_r, ovf_nxt;
  mstw_pkg::state_t st_r, st_nxt;
  // Merge sort bookkeeping. bank_r selects the source bank.
  logic bank_r, bank_nxt;
  logic [EW:0] wid_r, wid_nxt, lo_r, lo_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [EW:0] mid_r, mid_nxt, hi_r, hi_nxt;
  mstw_pkg::edge_t ei_r, ei_nxt;
  logic phase_r, phase_nxt; // 0 reading i, 1 reading j
  // Kruskal bookkeeping.
  logic [VW-1:0] va_r, va_nxt, vb_r, vb_nxt, ra_r, ra_nxt, rb_r, rb_nxt, cur_r, cur_nxt;
  logic [VW:0] taken_r, taken_nxt;
  logic [mstw_pkg::TOT_W-1:0] tot_r, tot_nxt;
  logic [15:0] w_r, w_nxt;
  mstw_pkg::out_word_t ow_r, ow_nxt;
  logic ov_r, ov_nxt;

  logic e_we; logic [EW:0] e_wa, e_ra; mstw_pkg::edge_t e_wd, e_rd;
  logic p_we; logic [VW-1:0] p_wa, p_wd, p_ra, p_rd;

  mstw_edge_ram u_edge (.clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra),
    .rdata(e_rd));
  mstw_parent_ram u_par (.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra),
    .rdata(p_rd));

  // Effective vertex count, clamped to 1..MAX_VERTICES.
  logic [VW:0] n_eff;
  always_comb begin
    if (vcount_r == '0) n_eff = (VW+1)'(1);
    else if ({1'b0, vcount_r} > 12'(mstw_pkg::MAX_VERTICES))
      n_eff = (VW+1)'(mstw_pkg::MAX_VERTICES);
    else n_eff = (VW+1)'(vcount_r);
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == mstw_pkg::REG_VCOUNT) ? {21'd0, vcount_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 11'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == mstw_pkg::REG_VCOUNT)
      vcount_r <= cfg_pwdata[10:0];
  end

  assign in_ch.ready = (st_r == mstw_pkg::S_LOAD) && !(ov_r && in_ch.data.last_edge);
  assign out_ch.valid = ov_r;
  assign out_ch.data = ow_r;

  logic [EW:0] src_base, dst_base;
  assign src_base = bank_r ? (EW+1)'(mstw_pkg::MAX_EDGES) : '0;
  assign dst_base = bank_r ? '0 : (EW+1)'(mstw_pkg::MAX_EDGES);

  always_comb begin
    logic acc;
    logic [EW+1:0] t;
    acc = in_ch.valid && in_ch.ready;
    st_nxt = st_r; fill_nxt = fill_r; ovf_nxt = ovf_r; bank_nxt = bank_r;
    wid_nxt = wid_r; lo_nxt = lo_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    mid_nxt = mid_r; hi_nxt = hi_r; ei_nxt = ei_r; phase_nxt = phase_r;
    va_nxt = va_r; vb_nxt = vb_r; ra_nxt = ra_r; rb_nxt = rb_r; cur_nxt = cur_r;
    taken_nxt = taken_r; tot_nxt = tot_r; w_nxt = w_r; ow_nxt = ow_r;
    ov_nxt = ov_r && !out_ch.ready;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
    t = '0;
    unique case (st_r)
      mstw_pkg::S_LOAD: begin
        if (acc) begin
          if (fill_r < (EW+1)'(mstw_pkg::MAX_EDGES)) begin
            e_we = 1'b1; e_wa = fill_r;
            e_wd = '{a: in_ch.data.end_a, b: in_ch.data.end_b,
                     w: in_ch.data.weight[mstw_pkg::WEIGHT_BITS-1:0]};
            fill_nxt = fill_r + 1'b1;
          end else ovf_nxt = 1'b1;
          if (in_ch.data.last_edge) begin
            st_nxt = mstw_pkg::S_INIT; cur_nxt = '0; bank_nxt = 1'b0;
            wid_nxt = (EW+1)'(1);
          end
        end
      end
      mstw_pkg::S_INIT: begin
        p_we = 1'b1; p_wa = cur_r; p_wd = cur_r;
        cur_nxt = cur_r + 1'b1;
        if ({1'b0, cur_r} == n_eff - 1'b1) st_nxt = mstw_pkg::S_SPASS;
        lo_nxt = '0;
      end
      mstw_pkg::S_SPASS: begin
        // Start of one merge of runs [lo,mid) and [mid,hi).
        if (wid_r >= fill_r) begin
          st_nxt = mstw_pkg::S_KRD; i_nxt = '0; taken_nxt = '0; tot_nxt = '0;
        end else if (lo_r >= fill_r) begin
          bank_nxt = !bank_r; wid_nxt = {wid_r[EW-1:0], 1'b0}; lo_nxt = '0;
        end else begin
          t = {1'b0, lo_r} + {1'b0, wid_r};
          mid_nxt = (t < {1'b0, fill_r}) ? t[EW:0] : fill_r;
          t = {1'b0, lo_r} + {wid_r, 1'b0};
          hi_nxt = (t < {1'b0, fill_r}) ? t[EW:0] : fill_r;
          i_nxt = lo_r; j_nxt = mid_nxt; k_nxt = lo_r; phase_nxt = 1'b0;
          st_nxt = mstw_pkg::S_SRD;
        end
      end
      mstw_pkg::S_SRD: begin
        if (i_r < mid_r && j_r < hi_r) begin
          e_ra = src_base + (phase_r ? j_r : i_r); st_nxt = mstw_pkg::S_SWAIT;
        end else if (i_r < mid_r || j_r < hi_r) begin
          phase_nxt = !(i_r < mid_r);
          e_ra = src_base + ((i_r < mid_r) ? i_r : j_r); st_nxt = mstw_pkg::S_SCOPY;
        end else begin
          lo_nxt = hi_r; st_nxt = mstw_pkg::S_SPASS;
        end
      end
      mstw_pkg::S_SWAIT: begin
        if (!phase_r) begin
          ei_nxt = e_rd; phase_nxt = 1'b1; e_ra = src_base + j_r; st_nxt = mstw_pkg::S_SCMP;
        end
      end
      mstw_pkg::S_SCMP: begin
        e_we = 1'b1; e_wa = dst_base + k_r; k_nxt = k_r + 1'b1;
        if (e_rd.w < ei_r.w) begin
          e_wd = e_rd; j_nxt = j_r + 1'b1;
        end else begin
          e_wd = ei_r; i_nxt = i_r + 1'b1;
        end
        phase_nxt = 1'b0; st_nxt = mstw_pkg::S_SRD;
      end
      // The read port registers every cycle, so the address is held until the
      // word is written.
      mstw_pkg::S_SCOPY: begin
        e_ra = src_base + (phase_r ? j_r : i_r); st_nxt = mstw_pkg::S_SCPW;
      end
      mstw_pkg::S_SCPW: begin
        e_we = 1'b1; e_wa = dst_base + k_r; e_wd = e_rd; k_nxt = k_r + 1'b1;
        if (phase_r) j_nxt = j_r + 1'b1; else i_nxt = i_r + 1'b1;
        phase_nxt = 1'b0; st_nxt = mstw_pkg::S_SRD;
      end
      mstw_pkg::S_KRD: begin
        if (i_r >= fill_r || taken_r == n_eff - 1'b1) st_nxt = mstw_pkg::S_DONE;
        else begin
          e_ra = src_base + i_r; st_nxt = mstw_pkg::S_KWAIT;
        end
      end
      mstw_pkg::S_KWAIT: begin
        e_ra = src_base + i_r; st_nxt = mstw_pkg::S_KCHK;
      end
      mstw_pkg::S_KCHK: begin
        i_nxt = i_r + 1'b1; w_nxt = 16'(e_rd.w);
        if (e_rd.a == '0 || e_rd.b == '0 || {1'b0, e_rd.a} > 12'(n_eff)
            || {1'b0, e_rd.b} > 12'(n_eff)) st_nxt = mstw_pkg::S_KRD;
        else begin
          va_nxt = VW'(e_rd.a - 1'b1); vb_nxt = VW'(e_rd.b - 1'b1);
          ra_nxt = VW'(e_rd.a - 1'b1); st_nxt = mstw_pkg::S_FA;
        end
      end
      // Root search for a: ra_r follows parents.
      mstw_pkg::S_FA: begin p_ra = ra_r; st_nxt = mstw_pkg::S_FAW; end
      mstw_pkg::S_FAW: begin
        if (p_rd == ra_r) begin cur_nxt = va_r; st_nxt = mstw_pkg::S_CA; end
        else begin ra_nxt = p_rd; p_ra = p_rd; end
      end
      // Path compression for a.
      mstw_pkg::S_CA: begin p_ra = cur_r; st_nxt = mstw_pkg::S_CAW; end
      mstw_pkg::S_CAW: begin
        if (p_rd == ra_r) begin rb_nxt = vb_r; st_nxt = mstw_pkg::S_FB; end
        else begin
          p_we = 1'b1; p_wa = cur_r; p_wd = ra_r; cur_nxt = p_rd; st_nxt = mstw_pkg::S_CA;
        end
      end
      mstw_pkg::S_FB: begin p_ra = rb_r; st_nxt = mstw_pkg::S_FBW; end
      mstw_pkg::S_FBW: begin
        if (p_rd == rb_r) begin cur_nxt = vb_r; st_nxt = mstw_pkg::S_CB; end
        else begin rb_nxt = p_rd; p_ra = p_rd; end
      end
      mstw_pkg::S_CB: begin p_ra = cur_r; st_nxt = mstw_pkg::S_CBW; end
      mstw_pkg::S_CBW: begin
        if (p_rd == rb_r) st_nxt = mstw_pkg::S_JOIN;
        else begin
          p_we = 1'b1; p_wa = cur_r; p_wd = rb_r; cur_nxt = p_rd; st_nxt = mstw_pkg::S_CB;
        end
      end
      mstw_pkg::S_JOIN: begin
        if (ra_r != rb_r) begin
          p_we = 1'b1; p_wa = ra_r; p_wd = rb_r;
          tot_nxt = tot_r + mstw_pkg::TOT_W'(w_r); taken_nxt = taken_r + 1'b1;
        end
        st_nxt = mstw_pkg::S_KRD;
      end
      mstw_pkg::S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ow_nxt.connected = (taken_r == n_eff - 1'b1);
          ow_nxt.total_weight = (taken_r == n_eff - 1'b1) ? tot_r : '0;
          ow_nxt.edges_dropped = ovf_r;
          fill_nxt = '0; ovf_nxt = 1'b0; st_nxt = mstw_pkg::S_LOAD;
        end
      end
      default: st_nxt = mstw_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mstw_pkg::S_LOAD; fill_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt; wid_r <= wid_nxt; lo_r <= lo_nxt; i_r <= i_nxt; j_r <= j_nxt;
    k_r <= k_nxt; mid_r <= mid_nxt; hi_r <= hi_nxt; ei_r <= ei_nxt;
    phase_r <= phase_nxt; va_r <= va_nxt; vb_r <= vb_nxt; ra_r <= ra_nxt;
    rb_r <= rb_nxt; cur_r <= cur_nxt; taken_r <= taken_nxt; tot_r <= tot_nxt;
    w_r <= w_nxt; ow_r <= ow_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/mstw_edge_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-bank edge store in one array, with one write and one registered read port shared by both banks.
module mstw_edge_ram (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [mstw_pkg::EW:0] waddr,
  input  wire mstw_pkg::edge_t wdata,
  input  wire logic [mstw_pkg::EW:0] raddr,
  output mstw_pkg::edge_t rdata
);
  mstw_pkg::edge_t mem [2*mstw_pkg::MAX_EDGES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/mstw_parent_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Union-find parent store with a registered read.
module mstw_parent_ram (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [mstw_pkg::VW-1:0] waddr,
  input  wire logic [mstw_pkg::VW-1:0] wdata,
  input  wire logic [mstw_pkg::VW-1:0] raddr,
  output logic [mstw_pkg::VW-1:0] rdata
);
  logic [mstw_pkg::VW-1:0] mem [mstw_pkg::MAX_VERTICES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/mstw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "minimum_spanning_tree_weight_macros.svh"
module mstw_sva (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic connected,
  input wire logic [25:0] total_weight,
  input wire logic cfg_pready
);
  `MSTW_ASSERT_IMP(a_zero_when_open, clk, rst_n, out_valid && !connected, total_weight == '0)
  `MSTW_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `MSTW_ASSERT_NEXT(a_total_holds, clk, rst_n, out_valid && !out_ready, $stable(total_weight))
  `MSTW_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, cfg_pready)
endmodule

bind minimum_spanning_tree_weight mstw_sva u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .connected(out_ch.data.connected), .total_weight(out_ch.data.total_weight),
  .cfg_pready(cfg_pready));
`default_nettype wire

// ----- tb/mstw_tb_if.sv -----
`timescale 1ns / 1ps
// The channel interfaces come from the RTL file mstw_if.sv.
// This file only gathers the configuration bus signals the bench drives.
interface mstw_cfg_bus;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mstw_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
endinterface

// ----- tb/mstw_checker.sv -----
`timescale 1ns / 1ps
module mstw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input mstw_pkg::in_word_t in_data,
  input logic out_valid,
  input logic out_ready,
  input mstw_pkg::out_word_t out_data,
  input logic [10:0] vcount_now,
  output int fail_count,
  output int pending_results
);
  typedef struct {
    int unsigned a;
    int unsigned b;
    int unsigned w;
  } graph_edge_t;

  graph_edge_t graph_edges[$];
  bit dropped_seen;
  int unsigned forest[mstw_pkg::MAX_VERTICES];
  mstw_pkg::out_word_t tree_results[$];

  function automatic int unsigned find_root(int unsigned v);
    int unsigned r;
    int unsigned nx;
    r = v;
    while (forest[r] != r) r = forest[r];
    while (forest[v] != r) begin
      nx = forest[v];
      forest[v] = r;
      v = nx;
    end
    return r;
  endfunction

  // Kruskal over the collected edges; a stable sort keeps the same ties.
  function automatic mstw_pkg::out_word_t solve_tree(int unsigned vc);
    graph_edge_t sorted[$];
    mstw_pkg::out_word_t res;
    int unsigned n;
    int unsigned taken;
    longint unsigned total;
    int unsigned ra;
    int unsigned rb;
    n = (vc == 0) ? 1 : (vc > mstw_pkg::MAX_VERTICES ? mstw_pkg::MAX_VERTICES : vc);
    for (int i = 0; i < n; i++) forest[i] = i;
    sorted = graph_edges;
    for (int i = 1; i < sorted.size(); i++) begin
      graph_edge_t e;
      int j;
      e = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j].w > e.w) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = e;
    end
    taken = 0;
    total = 0;
    foreach (sorted[i]) begin
      if (taken >= n - 1) break;
      if (sorted[i].a == 0 || sorted[i].b == 0 || sorted[i].a > n || sorted[i].b > n)
        continue;
      ra = find_root(sorted[i].a - 1);
      rb = find_root(sorted[i].b - 1);
      if (ra != rb) begin
        total += sorted[i].w;
        taken++;
        forest[ra] = rb;
      end
    end
    res.connected = (taken == n - 1);
    res.total_weight = res.connected ? total[mstw_pkg::TOT_W-1:0] : '0;
    res.edges_dropped = dropped_seen;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (graph_edges.size() < mstw_pkg::MAX_EDGES)
          graph_edges = {graph_edges,
                         graph_edge_t'{in_data.end_a, in_data.end_b,
                                       in_data.weight[mstw_pkg::WEIGHT_BITS-1:0]}};
        else
          dropped_seen = 1'b1;
        if (in_data.last_edge) begin
          tree_results = {tree_results, solve_tree(vcount_now)};
          graph_edges.delete();
          dropped_seen = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (tree_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          mstw_pkg::out_word_t exp_w;
          exp_w = tree_results.pop_front();
          if (out_data.total_weight !== exp_w.total_weight)
            report_mismatch($sformatf("total_weight %0d, expected %0d",
                                      out_data.total_weight, exp_w.total_weight));
          if (out_data.connected !== exp_w.connected)
            report_mismatch($sformatf("connected %0b, expected %0b",
                                      out_data.connected, exp_w.connected));
          if (out_data.edges_dropped !== exp_w.edges_dropped)
            report_mismatch($sformatf("edges_dropped %0b, expected %0b",
                                      out_data.edges_dropped, exp_w.edges_dropped));
        end
      end
      pending_results <= tree_results.size();
    end
  end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the bench. It builds graphs word by word, writes the vertex count
// between graphs, and leaves every prediction and comparison to the checker.
module tb;
  logic clk;
  logic rst_n;
  mstw_in_if in_ch ();
  mstw_out_if out_ch ();
  mstw_cfg_bus cfg ();

  // The checker needs the count that was live when each graph closed.
  logic [10:0] vcount_shadow;
  int fail_count;
  int pending_results;
  // Idle percentages for the sender and the receiver in the current phase.
  int send_idle_pct;
  int recv_stall_pct;

  minimum_spanning_tree_weight u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg.psel), .cfg_penable(cfg.penable), .cfg_pwrite(cfg.pwrite),
    .cfg_paddr(cfg.paddr), .cfg_pwdata(cfg.pwdata), .cfg_prdata(cfg.prdata),
    .cfg_pready(cfg.pready)
  );

  mstw_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .vcount_now(vcount_shadow), .fail_count(fail_count),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The receiver decides its ready on every edge from the current stall rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // A ceiling on simulation time that ends the run as a failure.
  initial begin
    #400ms;
    $display("FAIL minimum_spanning_tree_weight");
    $finish;
  end

  // APB write: setup, then access; pready is always high.
  // The task ends with the bus idle so that writes can be issued back to back.
  task automatic write_vertex_count(input int unsigned value);
    cfg.psel <= 1'b1;
    cfg.penable <= 1'b0;
    cfg.pwrite <= 1'b1;
    cfg.paddr <= mstw_pkg::REG_VCOUNT;
    cfg.pwdata <= value;
    @(posedge clk);
    cfg.penable <= 1'b1;
    @(posedge clk);
    cfg.psel <= 1'b0;
    cfg.penable <= 1'b0;
    cfg.pwrite <= 1'b0;
    vcount_shadow = value[10:0];
    @(posedge clk);
  endtask

  // Presents one edge word and holds it until the block takes it.
  task automatic send_edge(input int unsigned a, input int unsigned b,
                           input int unsigned w, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{end_a: a[10:0], end_b: b[10:0], weight: w[15:0], last_edge: last};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every solve has been answered, then lets the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly a chain that touches every vertex plus random extra edges,
  // so that connected graphs are common; some graphs are left sparse.
  task automatic send_random_graph(input int unsigned nv, input int unsigned n_edges);
    bit spanning;
    int unsigned a;
    int unsigned b;
    spanning = ($urandom_range(3) != 0);
    for (int i = 0; i < n_edges; i++) begin
      if (spanning && i + 1 < nv) begin
        a = i + 1;
        b = $urandom_range(i + 2, nv);
      end else if ($urandom_range(19) == 0) begin
        // Noise: any endpoint the field allows, out of range ones included.
        a = $urandom_range(2047);
        b = $urandom_range(2047);
      end else begin
        a = $urandom_range(1, nv);
        b = $urandom_range(1, nv);
      end
      send_edge(a, b, ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(15),
                i == n_edges - 1);
    end
  endtask

  initial begin
    int unsigned nv;
    int items_sent;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.psel = 1'b0;
    cfg.penable = 1'b0;
    cfg.pwrite = 1'b0;
    cfg.paddr = '0;
    cfg.pwdata = '0;
    vcount_shadow = 11'd1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A lone vertex is trivially spanned at reset value.
    send_edge(1, 1, 5, 1'b1);
    drain_results();
    write_vertex_count(4);
    // Square with a heavy diagonal, equal weights, a self loop and bad ends.
    send_edge(1, 2, 3, 1'b0);
    send_edge(2, 3, 3, 1'b0);
    send_edge(3, 3, 0, 1'b0);
    send_edge(0, 2, 1, 1'b0);
    send_edge(5, 1, 1, 1'b0);
    send_edge(1, 3, 65535, 1'b0);
    send_edge(3, 4, 3, 1'b0);
    send_edge(4, 1, 3, 1'b1);
    // Disconnected: vertex 4 never reached.
    send_edge(1, 2, 7, 1'b0);
    send_edge(2, 3, 9, 1'b1);
    drain_results();
    // Zero is treated as one vertex; over the maximum saturates.
    write_vertex_count(0);
    send_edge(2047, 1024, 65535, 1'b1);
    drain_results();
    write_vertex_count(2047);
    send_edge(1024, 1, 65535, 1'b0);
    send_edge(2047, 1, 0, 1'b1);
    drain_results();
    // Two vertices joined by the heaviest edge, after a count of 1024 is overwritten by 2.
    write_vertex_count(1024);
    write_vertex_count(2);
    send_edge(2, 1, 65535, 1'b1);
    drain_results();

    // Random phases with different idle patterns and vertex counts. The last
    // phase sends one large graph over the full vertex range.
    items_sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      nv = (phase == 7) ? 1024 : $urandom_range(1, 12);
      write_vertex_count(nv);
      while (items_sent < ((phase == 7) ? 1920 : (phase + 1) * 120)) begin
        int unsigned ne;
        ne = (nv > 100) ? $urandom_range(1080, 1120) : $urandom_range(1, 3 * nv + 2);
        send_random_graph(nv, ne);
        items_sent += ne;
      end
      drain_results();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();

    if (fail_count == 0) begin
      $display("PASS minimum_spanning_tree_weight");
    end else begin
      $display("FAIL minimum_spanning_tree_weight");
    end
    $finish;
  end
endmodule
